FILE: sv/unique_array_set_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unique array set engine
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ARRAY_SET_ENGINE_UNIT_MACROS_SVH
`define UNIQUE_ARRAY_SET_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define UASE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UASE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/uase_pkg.sv
// ----------------------------------------------------------------------------
// uase_pkg
// Shared types and codes of the unique array set engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uase_pkg;

    localparam int ACT_W   = 2;
    localparam int KEY_W   = 32;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;
    localparam int CAP_W   = 11;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key_value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/uase_mem.sv
// ----------------------------------------------------------------------------
// uase_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uase_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/uase_ctrl.sv
// ----------------------------------------------------------------------------
// uase_ctrl
// Request sequencer: linear scan, append, and shift-down on remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "unique_array_set_engine_unit_macros.svh"

module uase_ctrl
    import uase_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_vld,
    output logic                                req_rdy,
    input  wire req_t                           req,
    input  wire logic [CAP_W-1:0]               cap_limit,
    output logic                                res_vld,
    input  wire logic                           res_rdy,
    output res_t                                res,
    output logic                                wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
    output logic [VALUE_BITS-1:0]               wr_data,
    output logic                                rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
    input  wire logic [VALUE_BITS-1:0]          rd_data
);

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [ACT_W-1:0]       act_reg, act_next;
    logic [VALUE_BITS-1:0]  key_reg, key_next;
    logic [CW-1:0]          fill_count_reg, fill_count_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic [CW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]          pos_reg, pos_next;
    res_t                   res_reg, res_next;

    logic [VALUE_BITS-1:0]  key_ext;
    logic                   table_full;
    logic                   cmp_last;
    logic                   cmp_hit;
    logic [CW-1:0]          count_dec;
    logic [CW-1:0]          count_inc;

    generate
        if (VALUE_BITS <= KEY_W)
        begin : g_key_trunc
            assign key_ext = req.key_value[VALUE_BITS-1:0];
        end
        else
        begin : g_key_sext
            assign key_ext = {{(VALUE_BITS - KEY_W){req.key_value[KEY_W-1]}}, req.key_value};
        end
    endgenerate

    assign table_full = (CAPW'(fill_count_reg) >= CAPW'(cap_limit))
                     || (fill_count_reg == CW'(TABLE_DEPTH));
    assign count_dec  = CW'(fill_count_reg - 1'b1);
    assign count_inc  = CW'(fill_count_reg + 1'b1);
    assign cmp_last   = (cmp_idx_reg == count_dec);
    assign cmp_hit    = cmp_vld_reg && (rd_data == key_reg);

    assign req_rdy = (state_reg == S_IDLE);
    assign res_vld = (state_reg == S_RESP);
    assign res     = res_reg;
    assign rd_addr = scan_idx_reg[IW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        fill_count_next = fill_count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        pos_next        = pos_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = fill_count_reg[IW-1:0];
        wr_data         = key_reg;
        rd_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_vld)
                begin
                    act_next      = req.action;
                    key_next      = key_ext;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    if ((req.action == ACT_INSERT) && table_full)
                    begin
                        res_next   = '{ST_FULL, '0, COUNT_W'(fill_count_reg)};
                        state_next = S_RESP;
                    end
                    else if (fill_count_reg == '0)
                    begin
                        if (req.action == ACT_INSERT)
                        begin
                            wr_en           = 1'b1;
                            wr_data         = key_ext;
                            fill_count_next = count_inc;
                            res_next        = '{ST_DONE, '0, COUNT_W'(count_inc)};
                        end
                        else
                        begin
                            res_next = '{ST_MISSING, '0, COUNT_W'(fill_count_reg)};
                        end
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                rd_en         = (scan_idx_reg < fill_count_reg);
                scan_idx_next = CW'(scan_idx_reg + 1'b1);
                cmp_idx_next  = scan_idx_reg;
                cmp_vld_next  = rd_en;
                if (cmp_hit)
                begin
                    pos_next = cmp_idx_reg[IW-1:0];
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            res_next   = '{ST_DUP, POS_W'(cmp_idx_reg[IW-1:0]),
                                           COUNT_W'(fill_count_reg)};
                            state_next = S_RESP;
                        end
                        ACT_REMOVE:
                        begin
                            if (cmp_last)
                            begin
                                fill_count_next = count_dec;
                                res_next   = '{ST_DONE, POS_W'(cmp_idx_reg[IW-1:0]),
                                               COUNT_W'(count_dec)};
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            res_next   = '{ST_DONE, POS_W'(cmp_idx_reg[IW-1:0]),
                                           COUNT_W'(fill_count_reg)};
                            state_next = S_RESP;
                        end
                    endcase
                end
                else if (cmp_vld_reg && cmp_last)
                begin
                    if (act_reg == ACT_INSERT)
                    begin
                        wr_en           = 1'b1;
                        fill_count_next = count_inc;
                        res_next        = '{ST_DONE, POS_W'(fill_count_reg[IW-1:0]),
                                            COUNT_W'(count_inc)};
                    end
                    else
                    begin
                        res_next = '{ST_MISSING, '0, COUNT_W'(fill_count_reg)};
                    end
                    state_next = S_RESP;
                end
            end

            S_SHIFT:
            begin
                rd_en         = (scan_idx_reg < fill_count_reg);
                scan_idx_next = CW'(scan_idx_reg + 1'b1);
                cmp_idx_next  = scan_idx_reg;
                cmp_vld_next  = rd_en;
                if (cmp_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(cmp_idx_reg - 1'b1);
                    wr_data = rd_data;
                    if (cmp_last)
                    begin
                        fill_count_next = count_dec;
                        res_next   = '{ST_DONE, POS_W'(pos_reg), COUNT_W'(count_dec)};
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (res_rdy)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_LOOKUP;
            key_reg        <= '0;
            fill_count_reg <= '0;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            pos_reg        <= '0;
            res_reg        <= '{ST_DONE, '0, '0};
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            key_reg        <= key_next;
            fill_count_reg <= fill_count_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            pos_reg        <= pos_next;
            res_reg        <= res_next;
        end
    end

    `UASE_ASSERT_IMPL(a_rw_apart, wr_en && rd_en, wr_addr != rd_addr, "read and write hit one entry")
    `UASE_ASSERT_IMPL(a_count_bound, 1'b1, fill_count_reg <= CW'(TABLE_DEPTH), "count above depth")
    `UASE_ASSERT_IMPL(a_count_step, fill_count_reg != $past(fill_count_reg), (fill_count_reg == CW'($past(fill_count_reg) + 1'b1)) || (fill_count_reg == CW'($past(fill_count_reg) - 1'b1)), "count moved by more than one")
    `UASE_ASSERT_NEXT(a_res_hold, res_vld && !res_rdy, res_vld && $stable(res), "result dropped while stalled")

endmodule

`default_nettype wire

FILE: sv/unique_array_set_engine_unit.sv
// ----------------------------------------------------------------------------
// unique_array_set_engine_unit
// Unsorted set of distinct values in one memory, searched linearly.
// ----------------------------------------------------------------------------
// Sequence: a result is given without a scan when the table is empty or
//   an insert is refused as full; otherwise the entries are scanned up to
//   a hit or the last one, and a remove then shifts later entries down.
// Throughput: one request at a time; the single read port of the entry
//   memory scans one entry per cycle. A request can be taken while m_tvalid waits.
// Reset: fill count cleared, capacity set to 1024; the entry memory is not
//   cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module unique_array_set_engine_unit
    import uase_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] key_value
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [9:0] position, [20:10] entry_count
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data   // [10:0] capacity_limit
);

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [CAP_W-1:0]      capacity_reg;
    logic                  out_vld_reg;
    res_t                  out_res_reg;

    req_t                  req;
    res_t                  res;
    logic                  res_vld;
    logic                  res_rdy;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    assign req       = '{s_tuser, s_tdata};
    assign cfg_ready = 1'b1;
    assign res_rdy   = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {3'b000, out_res_reg.entry_count, out_res_reg.position};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            out_res_reg <= '{ST_DONE, '0, '0};
        end
        else if (res_rdy)
        begin
            out_vld_reg <= res_vld;
            if (res_vld)
            begin
                out_res_reg <= res;
            end
        end
    end

    uase_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_vld   (s_tvalid),
        .req_rdy   (s_tready),
        .req       (req),
        .cap_limit (capacity_reg),
        .res_vld   (res_vld),
        .res_rdy   (res_rdy),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    uase_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire
